/* hw/rtl/ascon128_aead_engine_macros.svh */
// assertion macros used by the ascon engine rtl
// no dependencies
`ifndef ASCON128_AEAD_ENGINE_MACROS_SVH
`define ASCON128_AEAD_ENGINE_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/asc_pkg.sv */
// shared types, constants and the round function for the ascon engine
// no dependencies
`default_nettype none

package asc_pkg;

    localparam logic [63:0] ASC_IV  = 64'h80400c0600000000;
    localparam logic [63:0] PAD_TOP = 64'h8000000000000000;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_AD    = 2'd1,
        CMD_TEXT  = 2'd2,
        CMD_FINAL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1,
        REG_DECRYPT  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_BLOCK,
        ST_PADRUN,
        ST_FINAL,
        ST_EMIT
    } eng_state_t;

    // classified item passed from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] blk;
        logic [63:0] mask;
        logic [3:0]  count;
        logic        last;
        logic        full;
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
    } work_t;

    typedef logic [4:0][63:0] state_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic state_t round_fn(input state_t si, input logic [3:0] r);
        logic [63:0] s0, s1, s2, s3, s4, t0, t1, t2, t3, t4;
        state_t so;
        s0 = si[0]; s1 = si[1]; s2 = si[2]; s3 = si[3]; s4 = si[4];
        s2 = s2 ^ {56'd0, 4'hf - r, r};
        s0 = s0 ^ s4; s4 = s4 ^ s3; s2 = s2 ^ s1;
        t0 = ~s0 & s1; t1 = ~s1 & s2; t2 = ~s2 & s3; t3 = ~s3 & s4; t4 = ~s4 & s0;
        s0 = s0 ^ t1; s1 = s1 ^ t2; s2 = s2 ^ t3; s3 = s3 ^ t4; s4 = s4 ^ t0;
        s1 = s1 ^ s0; s0 = s0 ^ s4; s3 = s3 ^ s2; s2 = ~s2;
        so[0] = s0 ^ rotr(s0, 19) ^ rotr(s0, 28);
        so[1] = s1 ^ rotr(s1, 61) ^ rotr(s1, 39);
        so[2] = s2 ^ rotr(s2, 1) ^ rotr(s2, 6);
        so[3] = s3 ^ rotr(s3, 10) ^ rotr(s3, 17);
        so[4] = s4 ^ rotr(s4, 7) ^ rotr(s4, 41);
        round_fn = so;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/asc_front.sv */
// front end: accepts items, normalizes byte counts and queues them
// depends on asc_pkg
`default_nettype none

module asc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [1:0]    command,
    input  wire logic [63:0]   block,
    input  wire logic [3:0]    byte_count,
    input  wire logic          last_block,
    input  wire logic [63:0]   nonce_high,
    input  wire logic [63:0]   nonce_low,
    output logic               work_valid,
    output asc_pkg::work_t     work,
    input  wire logic          work_take
);
    import asc_pkg::*;

    logic [QUEUE_DEPTH-1:0][$bits(work_t)-1:0] q_mem;
    logic [$clog2(QUEUE_DEPTH)-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] cnt_reg, cnt_next;
    logic [3:0] n;
    work_t item;
    logic do_push, do_pop;

    always_comb
    begin
        n = (byte_count > 4'd8) ? 4'd8 : byte_count;
        if (!last_block)
            n = 4'd8;
        item.cmd = cmd_t'(command);
        item.blk = block;
        item.count = n;
        item.mask = (n == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {n[3:0], 3'b000});
        item.last = last_block;
        item.full = (n == 4'd8);
        item.nonce_high = nonce_high;
        item.nonce_low = nonce_low;
    end

    assign full = (cnt_reg == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign work_valid = (cnt_reg != '0);
    assign do_pop = work_take && work_valid;
    assign work = work_t'(q_mem[rd_ptr_reg]);

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next = cnt_reg + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

`default_nettype wire

/* hw/rtl/asc_core.sv */
// back end: state register, round unit sequencer and result register
// depends on asc_pkg and the macros header
`default_nettype none
`include "ascon128_aead_engine_macros.svh"

module asc_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          work_valid,
    input  asc_pkg::work_t     work,
    output logic               work_take,
    input  wire logic [63:0]   key_high,
    input  wire logic [63:0]   key_low,
    input  wire logic          dec_select,
    output logic               empty,
    input  wire logic          pop,
    output logic               is_tag,
    output logic [63:0]        text_out,
    output logic [3:0]         valid_bytes,
    output logic [63:0]        tag_high,
    output logic [63:0]        tag_low
);
    import asc_pkg::*;

    eng_state_t st_reg, st_next;
    state_t s_reg, s_next;
    logic [3:0] rnd_reg, rnd_next;
    logic closed_reg, closed_next;
    work_t cur_reg, cur_next;
    logic res_valid_reg, res_valid_next;
    logic res_tag_reg, res_tag_next;
    logic [63:0] res_text_reg, res_text_next;
    logic [3:0] res_cnt_reg, res_cnt_next;
    logic [63:0] res_th_reg, res_th_next, res_tl_reg, res_tl_next;
    state_t rnd_out;
    logic [63:0] blkm, ad_pad;
    logic take;

    assign rnd_out = round_fn(s_reg, rnd_reg);
    assign blkm = work.blk & work.mask;
    assign ad_pad = work.full ? 64'd0 : (PAD_TOP >> {work.count, 3'b000});
    assign take = work_valid && (st_reg == ST_IDLE) && !(res_valid_reg && !pop);
    assign work_take = take;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (work.cmd)
                        CMD_START: st_next = ST_INIT;
                        CMD_AD:    st_next = closed_reg ? ST_IDLE : ST_BLOCK;
                        CMD_TEXT:  st_next = (!work.last || work.full) ? ST_BLOCK : ST_EMIT;
                        CMD_FINAL: st_next = ST_FINAL;
                        default:   st_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT, ST_FINAL:
                if (rnd_reg == 4'd11) st_next = (st_reg == ST_FINAL) ? ST_EMIT : ST_IDLE;
            ST_BLOCK:
            begin
                if (rnd_reg == 4'd11)
                begin
                    if (cur_reg.cmd == CMD_AD && cur_reg.last && cur_reg.full)
                        st_next = ST_PADRUN;
                    else if (cur_reg.cmd == CMD_TEXT)
                        st_next = ST_EMIT;
                    else
                        st_next = ST_IDLE;
                end
            end
            ST_PADRUN:
                if (rnd_reg == 4'd11) st_next = ST_IDLE;
            ST_EMIT:
                st_next = ST_IDLE;
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_next = s_reg;
        rnd_next = rnd_reg;
        closed_next = closed_reg;
        cur_next = cur_reg;
        res_valid_next = res_valid_reg && !pop;
        res_tag_next = res_tag_reg;
        res_text_next = res_text_reg;
        res_cnt_next = res_cnt_reg;
        res_th_next = res_th_reg;
        res_tl_next = res_tl_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    cur_next = work;
                    case (work.cmd)
                        CMD_START:
                        begin
                            s_next[0] = ASC_IV;
                            s_next[1] = key_high;
                            s_next[2] = key_low;
                            s_next[3] = work.nonce_high;
                            s_next[4] = work.nonce_low;
                            rnd_next = 4'd0;
                            closed_next = 1'b0;
                        end
                        CMD_AD:
                        begin
                            if (!closed_reg)
                            begin
                                s_next[0] = s_reg[0] ^ blkm ^ ad_pad;
                                rnd_next = 4'd6;
                            end
                        end
                        CMD_TEXT:
                        begin
                            if (!closed_reg)
                                s_next[4] = s_reg[4] ^ 64'd1;
                            closed_next = 1'b1;
                            if (dec_select)
                            begin
                                res_text_next = (s_reg[0] ^ blkm) & work.mask;
                                s_next[0] = blkm | (s_reg[0] & ~work.mask);
                            end
                            else
                            begin
                                s_next[0] = s_reg[0] ^ blkm;
                                res_text_next = (s_reg[0] ^ blkm) & work.mask;
                            end
                            // short last block: pad now, no rounds
                            if (work.last && !work.full)
                                s_next[0] = s_next[0] ^ ad_pad;
                            res_cnt_next = work.count;
                            res_tag_next = 1'b0;
                            res_th_next = 64'd0;
                            res_tl_next = 64'd0;
                            rnd_next = 4'd6;
                        end
                        CMD_FINAL:
                        begin
                            if (!closed_reg)
                                s_next[4] = s_reg[4] ^ 64'd1;
                            closed_next = 1'b1;
                            s_next[1] = s_reg[1] ^ key_high;
                            s_next[2] = s_reg[2] ^ key_low;
                            rnd_next = 4'd0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INIT, ST_FINAL, ST_BLOCK, ST_PADRUN:
            begin
                s_next = rnd_out;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'd11)
                begin
                    case (st_reg)
                        ST_INIT:
                        begin
                            s_next[3] = rnd_out[3] ^ key_high;
                            s_next[4] = rnd_out[4] ^ key_low;
                        end
                        ST_FINAL:
                        begin
                            res_tag_next = 1'b1;
                            res_text_next = 64'd0;
                            res_cnt_next = 4'd0;
                            res_th_next = rnd_out[3] ^ key_high;
                            res_tl_next = rnd_out[4] ^ key_low;
                        end
                        ST_BLOCK:
                        begin
                            if (cur_reg.cmd == CMD_AD && cur_reg.last)
                            begin
                                if (cur_reg.full)
                                begin
                                    s_next[0] = rnd_out[0] ^ PAD_TOP;
                                    rnd_next = 4'd6;
                                end
                                else
                                begin
                                    s_next[4] = rnd_out[4] ^ 64'd1;
                                    closed_next = 1'b1;
                                end
                            end
                            else if (cur_reg.cmd == CMD_TEXT && cur_reg.last)
                                s_next[0] = rnd_out[0] ^ PAD_TOP;
                        end
                        ST_PADRUN:
                        begin
                            s_next[4] = rnd_out[4] ^ 64'd1;
                            closed_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EMIT:
                res_valid_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_tag_reg <= res_tag_next;
        res_text_reg <= res_text_next;
        res_cnt_reg <= res_cnt_next;
        res_th_reg <= res_th_next;
        res_tl_reg <= res_tl_next;
        rnd_reg <= rnd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            s_reg <= '0;
            closed_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            s_reg <= s_next;
            closed_reg <= closed_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign empty = !res_valid_reg;
    assign is_tag = res_tag_reg;
    assign text_out = res_text_reg;
    assign valid_bytes = res_cnt_reg;
    assign tag_high = res_th_reg;
    assign tag_low = res_tl_reg;

    `ASC_ASSERT_IMPL(a_take_idle, clk, rst_n, work_take, st_reg == ST_IDLE, "take while busy")
    `ASC_ASSERT_IMPL(a_emit_free, clk, rst_n, st_reg == ST_EMIT, !res_valid_reg || pop, "emit over result")
    `ASC_ASSERT_NEXT(a_emit_valid, clk, rst_n, st_reg == ST_EMIT, res_valid_reg, "result lost")
endmodule

`default_nettype wire

/* hw/rtl/ascon128_aead_engine.sv */
// ascon-128 aead engine: the back end takes start/ad/text/finalize items from the queue head
// start 12 rounds, ad block 6 rounds (12 with a pad block), text 6 rounds then the emit state
// a short last text block skips the rounds and goes to emit; finalize 12 rounds then the emit state
// one shared round unit, one round a cycle; a two-entry queue decouples input from it
// output is a one-beat register; a waiting result holds off the next queued item
// reset clears control, the result flag, the phase flag and the state words
`default_nettype none

module ascon128_aead_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [1:0]    command,
    input  wire logic [63:0]   block,
    input  wire logic [3:0]    byte_count,
    input  wire logic          last_block,
    input  wire logic [63:0]   nonce_high,
    input  wire logic [63:0]   nonce_low,
    output logic               empty,
    input  wire logic          pop,
    output logic               is_tag,
    output logic [63:0]        text_out,
    output logic [3:0]         valid_bytes,
    output logic [63:0]        tag_high,
    output logic [63:0]        tag_low,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [63:0]   cfg_data
);
    import asc_pkg::*;

    logic [63:0] key_high_reg, key_low_reg;
    logic decrypt_reg;
    logic work_valid, work_take;
    work_t work;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= 64'd0;
            key_low_reg <= 64'd0;
            decrypt_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg <= cfg_data;
                REG_DECRYPT:  decrypt_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    asc_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .command(command), .block(block), .byte_count(byte_count),
        .last_block(last_block), .nonce_high(nonce_high), .nonce_low(nonce_low),
        .work_valid(work_valid), .work(work), .work_take(work_take)
    );

    asc_core u_core (
        .clk(clk), .rst_n(rst_n), .work_valid(work_valid), .work(work),
        .work_take(work_take), .key_high(key_high_reg), .key_low(key_low_reg),
        .dec_select(decrypt_reg), .empty(empty), .pop(pop), .is_tag(is_tag),
        .text_out(text_out), .valid_bytes(valid_bytes), .tag_high(tag_high),
        .tag_low(tag_low)
    );
endmodule

`default_nettype wire
